// ===== hdl/pcs_pkg.sv =====
// pcs_pkg: shared constants, types and helpers for the puct child select unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int MANT_BITS         = 30;
  localparam int WIN_W             = 40;
  localparam int PRIOR_W           = 17;
  localparam int IDX_W             = 10;
  localparam int CFG_W             = 20;
  localparam int EF_W              = 32;
  localparam int CFG_IDX_W         = 1;
  localparam int MAX_CHILDREN_DEF  = 1024;
  localparam int VISIT_BITS_DEF    = 24;

  localparam logic [PRIOR_W-1:0] ONE_Q    = PRIOR_W'(1) << FRAC_BITS;
  localparam logic [31:0]        LN2_Q32  = 32'd2977044472;
  localparam logic [CFG_W-1:0]   EB_RESET = CFG_W'(19652);
  localparam logic [CFG_W-1:0]   EI_RESET = CFG_W'(81920);

  localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_INIT = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NODE,
    S_NODE_WAIT,
    S_NORM,
    S_SQ_MUL,
    S_SQ_NORM,
    S_LN_MUL,
    S_LN_FIN,
    S_CHILD,
    S_CHILD_WAIT,
    S_SC1,
    S_SC2,
    S_SC3,
    S_OUT
  } pcs_state_t;

  typedef struct packed {
    logic load;
    logic node_start;
    logic node_cap;
    logic norm_shift;
    logic sq_mul;
    logic sq_norm;
    logic ln_mul;
    logic ln_fin;
    logic child_start;
    logic sc_mul1;
    logic sc_mul2;
    logic sc_upd;
    logic first;
    logic out_load;
  } pcs_cmd_t;

  typedef struct packed {
    logic node_idle;
    logic m_big;
    logic child_idle;
    logic closing;
  } pcs_sts_t;

  function automatic logic [PRIOR_W-1:0] sat_one(input logic [WIN_W-1:0] v);
    logic [PRIOR_W-1:0] r;
    r = (v > WIN_W'(ONE_Q)) ? ONE_Q : v[PRIOR_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pcs_div.sv =====
// pcs_div: restoring divider, one quotient bit per cycle
// uses no package
`timescale 1ns / 1ps
`default_nettype none
module pcs_div #(
  parameter int NW = 56,
  parameter int DW = 25
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [NW-1:0]              dividend,
  input  wire logic [DW-1:0]              divisor,
  input  wire logic [$clog2(NW+1)-1:0]    nbits,
  output logic                            busy,
  output logic [NW-1:0]                   quot
);

  localparam int CNTW = $clog2(NW+1);

  logic [NW-1:0]   a_r, a_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   d_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]     trial;
  logic            qbit;

  always_comb begin
    trial   = {rem_r, a_r[NW-1]};
    qbit    = (trial >= {1'b0, d_r});
    a_nxt   = a_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      a_nxt   = dividend << (CNTW'(NW) - nbits);
      rem_nxt = '0;
      cnt_nxt = nbits;
    end else if (cnt_r != '0) begin
      a_nxt   = {a_r[NW-2:0], qbit};
      rem_nxt = qbit ? DW'(trial - {1'b0, d_r}) : trial[DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = a_r;

endmodule
`default_nettype wire

// ===== hdl/pcs_sqrt.sv =====
// pcs_sqrt: bit-by-bit integer square root, one result bit per cycle
// uses no package
`timescale 1ns / 1ps
`default_nettype none
module pcs_sqrt #(
  parameter int IW = 56
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [IW-1:0]       radicand,
  output logic                     busy,
  output logic [IW/2-1:0]          root
);

  logic [IW:0]   n_r, n_nxt;
  logic [IW:0]   res_r, res_nxt;
  logic [IW-1:0] bit_r, bit_nxt;
  logic [IW:0]   sum;

  always_comb begin
    sum     = res_r + {1'b0, bit_r};
    n_nxt   = n_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    if (start) begin
      n_nxt   = {1'b0, radicand};
      res_nxt = '0;
      bit_nxt = IW'(1) << (IW - 2);
    end else if (bit_r != '0) begin
      if (n_r >= sum) begin
        n_nxt   = n_r - sum;
        res_nxt = (res_r >> 1) + {1'b0, bit_r};
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    res_r <= res_nxt;
  end

  assign busy = (bit_r != '0);
  assign root = res_r[IW/2-1:0];

endmodule
`default_nettype wire

// ===== hdl/pcs_datapath.sv =====
// pcs_datapath: node setup (log, root, mean), child scoring and best tracking
// depends on pcs_pkg, pcs_div, pcs_sqrt
`timescale 1ns / 1ps
`default_nettype none
module pcs_datapath #(
  parameter int MAX_CHILDREN = pcs_pkg::MAX_CHILDREN_DEF,
  parameter int VISIT_BITS   = pcs_pkg::VISIT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pcs_pkg::pcs_cmd_t                 cmd,
  output pcs_pkg::pcs_sts_t                      sts,
  input  wire logic                              cfg_we,
  input  wire logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pcs_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic [VISIT_BITS-1:0]             in_parent_visits,
  input  wire logic [pcs_pkg::WIN_W-1:0]         in_parent_win_sum,
  input  wire logic [VISIT_BITS-1:0]             in_child_visits,
  input  wire logic [pcs_pkg::WIN_W-1:0]         in_child_win_sum,
  input  wire logic [pcs_pkg::PRIOR_W-1:0]       in_child_prior,
  input  wire logic [pcs_pkg::PRIOR_W-1:0]       in_child_fixed_value,
  input  wire logic                              in_child_proven,
  input  wire logic                              in_last_child,
  output logic [pcs_pkg::IDX_W-1:0]              out_pick_index,
  output logic                                   out_all_proven,
  output logic [pcs_pkg::PRIOR_W-1:0]            out_parent_proven_value
);

  localparam int F     = pcs_pkg::FRAC_BITS;
  localparam int MB    = pcs_pkg::MANT_BITS;
  localparam int VB    = VISIT_BITS;
  localparam int PW    = pcs_pkg::PRIOR_W;
  localparam int NUMW  = ((VB > pcs_pkg::CFG_W) ? VB : pcs_pkg::CFG_W) + 1;
  localparam int NWA   = NUMW + MB;
  localparam int DWA   = ((VB + 1) > pcs_pkg::CFG_W) ? (VB + 1) : pcs_pkg::CFG_W;
  localparam int NWB   = pcs_pkg::WIN_W;
  localparam int CNTA  = $clog2(NWA + 1);
  localparam int CNTB  = $clog2(NWB + 1);
  localparam int SQIN  = ((VB + 2 * F + 1) / 2) * 2;
  localparam int SQW   = SQIN / 2;
  localparam int KW    = $clog2(NWA);
  localparam int LW    = KW + F;
  localparam int EFW   = pcs_pkg::EF_W;
  localparam int P1W   = EFW + SQW;
  localparam int T1W   = P1W - F;
  localparam int P2F   = T1W + PW;
  localparam int P2W   = (P2F > 64) ? 64 : P2F;
  localparam int SCW   = P2W - F + 1;
  localparam int CW    = $clog2(MAX_CHILDREN);
  localparam int CFG_W_L = pcs_pkg::CFG_W;

  // configuration
  logic [pcs_pkg::CFG_W-1:0] eb_r, ei_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eb_r <= pcs_pkg::EB_RESET;
      ei_r <= pcs_pkg::EI_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pcs_pkg::REG_EXPLORE_BASE) begin
        eb_r <= cfg_data;
      end
      if (cfg_index == pcs_pkg::REG_EXPLORE_INIT) begin
        ei_r <= cfg_data;
      end
    end
  end

  // latched beat
  logic [VB-1:0]    pv_r, cv_r;
  logic [NWB-1:0]   pw_r, cw_r;
  logic [PW-1:0]    prior_r, fixed_r;
  logic             proven_r, last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pv_r     <= in_parent_visits;
      pw_r     <= in_parent_win_sum;
      cv_r     <= in_child_visits;
      cw_r     <= in_child_win_sum;
      prior_r  <= in_child_prior;
      fixed_r  <= pcs_pkg::sat_one(NWB'(in_child_fixed_value));
      proven_r <= in_child_proven;
      last_r   <= in_last_child;
    end
  end

  // iterative units: dividers shared by node setup and child scoring, root for node setup
  logic [NWA-1:0]   a_dividend, a_quot;
  logic [DWA-1:0]   a_divisor;
  logic [CNTA-1:0]  a_nbits;
  logic             a_busy, a_start;
  logic [NWB-1:0]   b_dividend, b_quot;
  logic [VB-1:0]    b_divisor;
  logic [CNTB-1:0]  b_nbits;
  logic             b_busy, b_start;
  logic             s_busy;
  logic [SQW-1:0]   s_root;
  logic [SQW-1:0]   s_root_r, initu_r;
  logic [CFG_W_L-1:0] base_eff;
  logic [NUMW-1:0]  num;
  logic [VB:0]      cv1;

  always_comb begin
    base_eff = (eb_r == '0) ? CFG_W_L'(1) : eb_r;
    num      = NUMW'(pv_r) + NUMW'(base_eff) + NUMW'(1);
    cv1      = {1'b0, cv_r} + 1'b1;
    a_start  = cmd.node_start | cmd.child_start;
    b_start  = cmd.node_start | cmd.child_start;
    if (cmd.node_start) begin
      a_dividend = {num, {MB{1'b0}}};
      a_divisor  = DWA'(base_eff);
      a_nbits    = CNTA'(NWA);
      b_dividend = pw_r;
      b_divisor  = pv_r;
    end else begin
      a_dividend = NWA'(s_root_r);
      a_divisor  = DWA'(cv1);
      a_nbits    = CNTA'(SQW);
      b_dividend = cw_r;
      b_divisor  = cv_r;
    end
    b_nbits = CNTB'(NWB);
  end

  pcs_div #(.NW(NWA), .DW(DWA)) u_div_a (
    .clk(clk), .rst_n(rst_n), .start(a_start), .dividend(a_dividend),
    .divisor(a_divisor), .nbits(a_nbits), .busy(a_busy), .quot(a_quot)
  );

  pcs_div #(.NW(NWB), .DW(VB)) u_div_b (
    .clk(clk), .rst_n(rst_n), .start(b_start), .dividend(b_dividend),
    .divisor(b_divisor), .nbits(b_nbits), .busy(b_busy), .quot(b_quot)
  );

  pcs_sqrt #(.IW(SQIN)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.node_start),
    .radicand(SQIN'({pv_r, {(2 * F){1'b0}}})), .busy(s_busy), .root(s_root)
  );

  // node constants
  logic [PW-1:0]    pmean_r;
  logic [NWA-1:0]   m_r;
  logic [KW-1:0]    k_r;
  logic [F-1:0]     frac_r;
  logic [61:0]      sq_full, sq_r;
  logic [31:0]      mm;
  logic [LW+31:0]   ln_full, ln_r;
  logic [EFW-1:0]   ef_r;

  assign sq_full = m_r[MB:0] * m_r[MB:0];
  assign mm      = sq_r[61:MB];
  assign ln_full = {k_r, frac_r} * pcs_pkg::LN2_Q32;

  always_ff @(posedge clk) begin
    if (cmd.node_cap) begin
      s_root_r <= s_root;
      initu_r  <= (pv_r == '0) ? SQW'(pcs_pkg::ONE_Q) : s_root;
      pmean_r  <= (pv_r != '0 && pw_r != '0) ? pcs_pkg::sat_one(b_quot) : '0;
      m_r      <= a_quot;
      k_r      <= '0;
      frac_r   <= '0;
    end else if (cmd.norm_shift) begin
      m_r <= m_r >> 1;
      k_r <= k_r + 1'b1;
    end else if (cmd.sq_norm) begin
      if (mm[31]) begin
        m_r    <= NWA'(mm[31:1]);
        frac_r <= {frac_r[F-2:0], 1'b1};
      end else begin
        m_r    <= NWA'(mm);
        frac_r <= {frac_r[F-2:0], 1'b0};
      end
    end
    if (cmd.sq_mul) begin
      sq_r <= sq_full;
    end
    if (cmd.ln_mul) begin
      ln_r <= ln_full;
    end
    if (cmd.ln_fin) begin
      ef_r <= EFW'(ln_r[LW+31:32]) + EFW'(ei_r);
    end
  end

  // child scoring
  logic [PW-1:0]    q_sel, q_r;
  logic [SQW-1:0]   u_sel;
  logic [P1W-1:0]   p1_full, p1_r;
  logic [T1W-1:0]   t1;
  logic [P2F-1:0]   p2_full;
  logic [P2W-1:0]   p2_r;
  logic [SCW-1:0]   score;

  always_comb begin
    if (proven_r) begin
      q_sel = fixed_r;
      u_sel = a_quot[SQW-1:0];
    end else if (cv_r == '0) begin
      q_sel = pmean_r;
      u_sel = initu_r;
    end else begin
      q_sel = pcs_pkg::sat_one(b_quot);
      u_sel = a_quot[SQW-1:0];
    end
  end

  assign p1_full = ef_r * u_sel;
  assign t1      = p1_r[P1W-1:F];
  assign p2_full = t1 * prior_r;
  assign score   = SCW'(q_r) + SCW'(p2_r[P2W-1:F]);

  always_ff @(posedge clk) begin
    if (cmd.sc_mul1) begin
      q_r  <= q_sel;
      p1_r <= p1_full;
    end
    if (cmd.sc_mul2) begin
      p2_r <= p2_full[P2W-1:0];
    end
  end

  // run tracking
  logic [CW-1:0]    cnt_r;
  logic [SCW-1:0]   best_r;
  logic [CW-1:0]    bpos_r;
  logic             allp_r;
  logic [PW-1:0]    bpv_r;
  logic             closing;

  assign closing = last_r || (cnt_r == CW'(MAX_CHILDREN - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.sc_upd) begin
      cnt_r <= closing ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sc_upd) begin
      if (cmd.first || score > best_r) begin
        best_r <= score;
        bpos_r <= cnt_r;
      end
      allp_r <= (cmd.first ? 1'b1 : allp_r) & proven_r;
      if (cmd.first) begin
        bpv_r <= proven_r ? fixed_r : '0;
      end else if (proven_r && fixed_r > bpv_r) begin
        bpv_r <= fixed_r;
      end
    end
    if (cmd.out_load) begin
      out_pick_index          <= pcs_pkg::IDX_W'(bpos_r);
      out_all_proven          <= allp_r;
      out_parent_proven_value <= allp_r ? PW'(pcs_pkg::ONE_Q - bpv_r) : '0;
    end
  end

  assign sts.node_idle  = !a_busy && !b_busy && !s_busy;
  assign sts.child_idle = !a_busy && !b_busy;
  assign sts.m_big      = |m_r[NWA-1:MB+1];
  assign sts.closing    = closing;

endmodule
`default_nettype wire

// ===== hdl/pcs_ctrl.sv =====
// pcs_ctrl: sequencer for node setup, child scoring and result hand-off
// depends on pcs_pkg
`timescale 1ns / 1ps
`default_nettype none
module pcs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire pcs_pkg::pcs_sts_t  sts,
  output pcs_pkg::pcs_cmd_t       cmd
);

  localparam int SQCW = $clog2(pcs_pkg::FRAC_BITS);

  pcs_pkg::pcs_state_t state_r, state_nxt;
  logic                in_run_r, in_run_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SQCW-1:0]     sq_cnt_r, sq_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcs_pkg::S_IDLE;
      in_run_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sq_cnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      in_run_r    <= in_run_nxt;
      out_valid_r <= out_valid_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_run_nxt = in_run_r;
    sq_cnt_nxt = sq_cnt_r;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    case (state_r)
      pcs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_run_r ? pcs_pkg::S_CHILD : pcs_pkg::S_NODE;
        end
      end
      pcs_pkg::S_NODE: begin
        cmd.node_start = 1'b1;
        state_nxt      = pcs_pkg::S_NODE_WAIT;
      end
      pcs_pkg::S_NODE_WAIT: begin
        if (sts.node_idle) begin
          cmd.node_cap = 1'b1;
          state_nxt    = pcs_pkg::S_NORM;
        end
      end
      pcs_pkg::S_NORM: begin
        if (sts.m_big) begin
          cmd.norm_shift = 1'b1;
        end else begin
          state_nxt = pcs_pkg::S_SQ_MUL;
        end
      end
      pcs_pkg::S_SQ_MUL: begin
        cmd.sq_mul = 1'b1;
        state_nxt  = pcs_pkg::S_SQ_NORM;
      end
      pcs_pkg::S_SQ_NORM: begin
        cmd.sq_norm = 1'b1;
        if (sq_cnt_r == SQCW'(pcs_pkg::FRAC_BITS - 1)) begin
          sq_cnt_nxt = '0;
          state_nxt  = pcs_pkg::S_LN_MUL;
        end else begin
          sq_cnt_nxt = sq_cnt_r + 1'b1;
          state_nxt  = pcs_pkg::S_SQ_MUL;
        end
      end
      pcs_pkg::S_LN_MUL: begin
        cmd.ln_mul = 1'b1;
        state_nxt  = pcs_pkg::S_LN_FIN;
      end
      pcs_pkg::S_LN_FIN: begin
        cmd.ln_fin = 1'b1;
        state_nxt  = pcs_pkg::S_CHILD;
      end
      pcs_pkg::S_CHILD: begin
        cmd.child_start = 1'b1;
        state_nxt       = pcs_pkg::S_CHILD_WAIT;
      end
      pcs_pkg::S_CHILD_WAIT: begin
        if (sts.child_idle) begin
          state_nxt = pcs_pkg::S_SC1;
        end
      end
      pcs_pkg::S_SC1: begin
        cmd.sc_mul1 = 1'b1;
        state_nxt   = pcs_pkg::S_SC2;
      end
      pcs_pkg::S_SC2: begin
        cmd.sc_mul2 = 1'b1;
        state_nxt   = pcs_pkg::S_SC3;
      end
      pcs_pkg::S_SC3: begin
        cmd.sc_upd = 1'b1;
        cmd.first  = !in_run_r;
        in_run_nxt = !sts.closing;
        state_nxt  = sts.closing ? pcs_pkg::S_OUT : pcs_pkg::S_IDLE;
      end
      pcs_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pcs_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_close_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sc_upd && sts.closing) |=> (state_r == pcs_pkg::S_OUT))
    else $error("closing child did not reach result state");

  a_first_to_node: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_run_r) |=> (state_r == pcs_pkg::S_NODE))
    else $error("first child of a node skipped node setup");

  a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcs_pkg::S_CHILD_WAIT && !sts.child_idle)
      |=> (state_r == pcs_pkg::S_CHILD_WAIT))
    else $error("left child wait with dividers busy");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == pcs_pkg::S_OUT))
    else $error("result raised outside result state");

endmodule
`default_nettype wire

// ===== hdl/puct_child_select_unit.sv =====
// puct_child_select_unit: top level, controller plus datapath
// depends on pcs_pkg, pcs_ctrl, pcs_datapath
//
// Scores the children of one search node, one beat per child, as
// q + c*u*prior and returns the first best position on the closing child.
// Each child's pace is set by the 40-step win-over-visits divider, the
// longer of it and the exploration divider that runs beside it; the
// closing child adds a state to load the result. The first child of a
// node adds node setup: the log-ratio divide (55 steps at default widths),
// a normalising shift of up to 24 steps and 16 squarings. A result waits
// in an output register and does not hold up the next child beat until a
// later result.
`timescale 1ns / 1ps
`default_nettype none
module puct_child_select_unit #(
  parameter int MAX_CHILDREN = pcs_pkg::MAX_CHILDREN_DEF,
  parameter int VISIT_BITS   = pcs_pkg::VISIT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pcs_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [VISIT_BITS-1:0]          in_parent_visits,
  input  wire logic [pcs_pkg::WIN_W-1:0]      in_parent_win_sum,
  input  wire logic [VISIT_BITS-1:0]          in_child_visits,
  input  wire logic [pcs_pkg::WIN_W-1:0]      in_child_win_sum,
  input  wire logic [pcs_pkg::PRIOR_W-1:0]    in_child_prior,
  input  wire logic [pcs_pkg::PRIOR_W-1:0]    in_child_fixed_value,
  input  wire logic                           in_child_proven,
  input  wire logic                           in_last_child,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [pcs_pkg::IDX_W-1:0]           out_pick_index,
  output logic                                out_all_proven,
  output logic [pcs_pkg::PRIOR_W-1:0]         out_parent_proven_value
);

  pcs_pkg::pcs_cmd_t cmd;
  pcs_pkg::pcs_sts_t sts;

  pcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  pcs_datapath #(.MAX_CHILDREN(MAX_CHILDREN), .VISIT_BITS(VISIT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_parent_visits(in_parent_visits), .in_parent_win_sum(in_parent_win_sum),
    .in_child_visits(in_child_visits), .in_child_win_sum(in_child_win_sum),
    .in_child_prior(in_child_prior), .in_child_fixed_value(in_child_fixed_value),
    .in_child_proven(in_child_proven), .in_last_child(in_last_child),
    .out_pick_index(out_pick_index), .out_all_proven(out_all_proven),
    .out_parent_proven_value(out_parent_proven_value)
  );

endmodule
`default_nettype wire
